FILE: hdl/gray4_pkg.sv
// ---------------------------------------------------------------------------
// gray4_pkg
// shared codes, types and gray conversion for the packed gray pixel engine
// ---------------------------------------------------------------------------
package gray4_pkg;

  typedef enum logic [2:0] {
    CMD_FILL  = 3'd0,
    CMD_SOLID = 3'd1,
    CMD_RGB   = 3'd2,
    CMD_BLEND = 3'd3,
    CMD_SPAN  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FG_COLOR    = 3'd0,
    REG_BG_COLOR    = 3'd1,
    REG_ALPHA_DEPTH = 3'd2,
    REG_CLIP_LEFT   = 3'd3,
    REG_CLIP_TOP    = 3'd4,
    REG_CLIP_RIGHT  = 3'd5,
    REG_CLIP_BOTTOM = 3'd6
  } reg_idx_t;

  localparam int MAX_BEATS = 64;

  // sum / 3 by reciprocal, exact for sums below 2048, then >> 4
  function automatic logic [3:0] gray_of_sum(input logic [9:0] s);
    logic [19:0] p;
    begin
      p = 20'(s) * 20'd683;
      gray_of_sum = p[18:15];
    end
  endfunction

  function automatic logic [3:0] gray_of_color(input logic [23:0] c);
    logic [9:0] s;
    begin
      s = 10'(c[23:16]) + 10'(c[15:8]) + 10'(c[7:0]);
      gray_of_color = gray_of_sum(s);
    end
  endfunction

endpackage

FILE: hdl/gray4_store.sv
// ---------------------------------------------------------------------------
// gray4_store
// frame byte memory, one write and one read port, registered read data
// ---------------------------------------------------------------------------
module gray4_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/gray4_div.sv
// ---------------------------------------------------------------------------
// gray4_div
// restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle
// ---------------------------------------------------------------------------
module gray4_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic        done,
  output logic [7:0]  quot
);

  logic [15:0] num_r, num_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[15]};
    if (start) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      cnt_nxt = 5'd16;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // quotient bits shift into the low end of the dividend register
      if (trial >= {2'b0, den_r}) begin
        rem_nxt = 9'(trial - {2'b0, den_r});
        num_nxt = {num_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[8:0];
        num_nxt = {num_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r[7:0];

endmodule

FILE: hdl/gray4_framebuffer_pixel_engine.sv
// ---------------------------------------------------------------------------
// gray4_framebuffer_pixel_engine
// packed 4-bit gray frame buffer with fill, pixel write, blend and row read
// ---------------------------------------------------------------------------
// channel   ports                              handshake
// command   start, busy, in_*                  beat when start & !busy
// result    out_valid, out_pixel_pair, out_last beat when out_valid, no stall
// config    cfg_valid, cfg_ready, cfg_index,   beat when valid & ready
//           cfg_data
//
// solid and rgb pixel writes read then write one byte.
// blended writes run three 16-step divisions in one divider, then read and write the byte.
// fill writes one store byte per cycle.
// row readout reads one byte per cycle; each beat follows in the cycle after its read.
// after reset busy stays high for one clearing pass over the store
// (ROW_BYTES * PANEL_HEIGHT bytes, 8192 at the default size).
// ---------------------------------------------------------------------------
module gray4_framebuffer_pixel_engine
  import gray4_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [6:0]  in_x,
  input  logic [6:0]  in_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_span_width,
  output logic        out_valid,
  output logic [7:0]  out_pixel_pair,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [8:0]  W9     = 9'(PANEL_WIDTH);
  localparam logic [8:0]  H9     = 9'(PANEL_HEIGHT);
  localparam logic [8:0]  EDGE9  = 9'(((PANEL_WIDTH + 1) / 2) * 2);
  localparam logic [17:0] ROWB18 = 18'(ROW_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  typedef enum logic [6:0] {
    ST_SWEEP = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WRITE = 7'b0000100,
    ST_MIX   = 7'b0001000,
    ST_MWAIT = 7'b0010000,
    ST_MGRAY = 7'b0100000,
    ST_SPAN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0] fg_r, bg_r;
  logic [3:0]  depth_r;
  logic [6:0]  cl_left_r, cl_top_r, cl_right_r, cl_bottom_r;

  logic [AW-1:0] addr_r, addr_nxt;
  logic          odd_r, odd_nxt;
  logic [3:0]    gray_r, gray_nxt;
  logic [7:0]    sweep_val_r, sweep_val_nxt;
  logic [7:0]    alpha_r, alpha_nxt;
  logic [7:0]    max_r, max_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic [9:0]    sum_r, sum_nxt;
  logic [6:0]    remain_r, remain_nxt;
  logic          ov_r, ov_nxt;
  logic          last_r, last_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic        div_start, div_done;
  logic [15:0] div_num;
  logic [7:0]  div_quot;

  logic          accept;
  logic          pix_hit;
  logic [17:0]   pix_lin;
  logic [AW-1:0] pix_addr;
  logic [3:0]    dsat;
  logic [8:0]    max9;
  logic [7:0]    max8, asat;
  logic [3:0]    bg_gray;
  logic [8:0]    left9, right_raw9, right9, diff9;
  logic [7:0]    cnt8;
  logic [6:0]    span_cnt;
  logic          span_ok;
  logic [7:0]    f_ch, b_ch;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // pixel address and clip test
  assign pix_lin  = 18'(in_y) * ROWB18 + 18'(in_x[6:1]);
  assign pix_addr = pix_lin[AW-1:0];
  assign pix_hit  = (in_x >= cl_left_r) && (in_x <= cl_right_r) &&
                    (in_y >= cl_top_r) && (in_y <= cl_bottom_r) &&
                    ({2'b0, in_x} < W9) && ({2'b0, in_y} < H9);

  // blend depth and alpha saturation
  always_comb begin
    dsat = depth_r;
    if (depth_r == 4'd0) dsat = 4'd1;
    if (depth_r > 4'd8)  dsat = 4'd8;
    max9 = 9'((10'd1 << dsat) - 10'd1);
    max8 = max9[7:0];
    asat = (in_alpha > max8) ? max8 : in_alpha;
  end

  assign bg_gray = gray_of_color(bg_r);

  // span edges
  always_comb begin
    left9      = {2'b0, in_x[6:1], 1'b0};
    right_raw9 = 9'({2'b0, in_x} + {1'b0, in_span_width} + 9'd1);
    right9     = {right_raw9[8:1], 1'b0};
    if (right9 > EDGE9) right9 = EDGE9;
    span_ok  = ({2'b0, in_y} < H9) && (right9 > left9);
    diff9    = right9 - left9;
    cnt8     = diff9[8:1];
    span_cnt = (cnt8 > 8'(MAX_BEATS)) ? 7'(MAX_BEATS) : cnt8[6:0];
  end

  // channel operands for the blend numerator
  always_comb begin
    case (ch_r)
      2'd0:    begin f_ch = fg_r[23:16]; b_ch = bg_r[23:16]; end
      2'd1:    begin f_ch = fg_r[15:8];  b_ch = bg_r[15:8];  end
      default: begin f_ch = fg_r[7:0];   b_ch = bg_r[7:0];   end
    endcase
    div_num = 16'(f_ch) * 16'(alpha_r) + 16'(b_ch) * 16'(max_r - alpha_r);
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    odd_nxt       = odd_r;
    gray_nxt      = gray_r;
    sweep_val_nxt = sweep_val_r;
    alpha_nxt     = alpha_r;
    max_nxt       = max_r;
    ch_nxt        = ch_r;
    sum_nxt       = sum_r;
    remain_nxt    = remain_r;
    ov_nxt        = 1'b0;
    last_nxt      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = sweep_val_r;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;
    div_start     = 1'b0;

    case (state_r)
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_FILL: begin
              sweep_val_nxt = {bg_gray, bg_gray};
              addr_nxt      = '0;
              state_nxt     = ST_SWEEP;
            end
            CMD_SOLID, CMD_RGB: begin
              if (pix_hit) begin
                mem_re    = 1'b1;
                mem_raddr = pix_addr;
                addr_nxt  = pix_addr;
                odd_nxt   = in_x[0];
                gray_nxt  = (in_command == CMD_SOLID) ? gray_of_color(fg_r) :
                            gray_of_color({in_red, in_green, in_blue});
                state_nxt = ST_WRITE;
              end
            end
            CMD_BLEND: begin
              if (pix_hit) begin
                addr_nxt  = pix_addr;
                odd_nxt   = in_x[0];
                alpha_nxt = asat;
                max_nxt   = max8;
                ch_nxt    = 2'd0;
                sum_nxt   = '0;
                state_nxt = ST_MIX;
              end
            end
            CMD_SPAN: begin
              if (span_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = pix_lin[AW-1:0];
                addr_nxt   = pix_lin[AW-1:0] + AW'(1);
                remain_nxt = span_cnt - 7'd1;
                ov_nxt     = 1'b1;
                last_nxt   = (span_cnt == 7'd1);
                state_nxt  = (span_cnt == 7'd1) ? ST_IDLE : ST_SPAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = odd_r ? {mem_rdata[7:4], gray_r} : {gray_r, mem_rdata[3:0]};
        state_nxt = ST_IDLE;
      end
      ST_MIX: begin
        div_start = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (div_done) begin
          sum_nxt = sum_r + 10'(div_quot);
          if (ch_r == 2'd2) begin
            state_nxt = ST_MGRAY;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MGRAY: begin
        gray_nxt  = gray_of_sum(sum_r);
        mem_re    = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_SPAN: begin
        mem_re     = 1'b1;
        addr_nxt   = addr_r + AW'(1);
        remain_nxt = remain_r - 7'd1;
        ov_nxt     = 1'b1;
        if (remain_r == 7'd1) begin
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      addr_r      <= '0;
      sweep_val_r <= '0;
      ov_r        <= 1'b0;
      last_r      <= 1'b0;
      ch_r        <= '0;
      remain_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      sweep_val_r <= sweep_val_nxt;
      ov_r        <= ov_nxt;
      last_r      <= last_nxt;
      ch_r        <= ch_nxt;
      remain_r    <= remain_nxt;
    end
    odd_r   <= odd_nxt;
    gray_r  <= gray_nxt;
    alpha_r <= alpha_nxt;
    max_r   <= max_nxt;
    sum_r   <= sum_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= '0;
      bg_r        <= '0;
      depth_r     <= 4'd1;
      cl_left_r   <= '0;
      cl_top_r    <= '0;
      cl_right_r  <= 7'd127;
      cl_bottom_r <= 7'd127;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FG_COLOR:    fg_r        <= cfg_data;
        REG_BG_COLOR:    bg_r        <= cfg_data;
        REG_ALPHA_DEPTH: depth_r     <= cfg_data[3:0];
        REG_CLIP_LEFT:   cl_left_r   <= cfg_data[6:0];
        REG_CLIP_TOP:    cl_top_r    <= cfg_data[6:0];
        REG_CLIP_RIGHT:  cl_right_r  <= cfg_data[6:0];
        REG_CLIP_BOTTOM: cl_bottom_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  gray4_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gray4_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (max_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid      = ov_r;
  assign out_pixel_pair = mem_rdata;
  assign out_last       = last_r;

endmodule
